// ===== rtl/assert_macros.svh =====
// assertion macros shared by the bit packer rtl
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RGBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgbp_pkg.sv =====
// package for the rice / exp-golomb bit packer
// field widths, command codes and the coder-to-packer transaction type
package rgbp_pkg;

  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 32;
  localparam int CB_W        = 12;
  localparam int LIMIT_W     = 24;
  localparam int NBITS_W     = 6;
  localparam int BYTES_MAX   = 4;
  localparam int POS_W_DEF   = 24;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  localparam logic [CMD_W-1:0] CMD_ENCODE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] bits;      // code, left justified
    logic [NBITS_W-1:0] nbits;     // 1 to 32
    logic               fallback;
  } code_t;

endpackage

// ===== rtl/rice_exp_golomb_bit_packer_unit.sv =====
// Adaptive rice / exp-golomb bit packer. Unless in_stall is set, one transaction
// is accepted per cycle into a three-stage pipe (input register, code register, byte
// buffer); the first byte of an item is presented from the byte buffer once the item has
// passed the input and code registers. The result channel carries one byte per cycle while
// out_stall is low, so an item that completes k bytes (0 to 4) holds the byte buffer until
// its last byte is taken, and the next item with bytes loads as that byte drains.
// Flush pads the partial byte with zeros, restart clears the bit and byte position, and
// bytes at or past byte_limit are dropped. fallback_seen is sticky until reset.
// depends on rgbp_pkg, rgbp_coder and assert_macros.svh
module rice_exp_golomb_bit_packer_unit #(
  parameter int POSITION_WIDTH = rgbp_pkg::POS_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rgbp_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rgbp_pkg::CMD_W-1:0]    in_command,
  input  logic [rgbp_pkg::VALUE_W-1:0]  in_value,
  input  logic [rgbp_pkg::CB_W-1:0]     in_codebook,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic [POSITION_WIDTH-1:0]     out_byte_position,
  output logic                          out_last_of_run,
  output logic                          out_fallback_seen
);
  import rgbp_pkg::*;

  `include "assert_macros.svh"

  localparam int PW  = POSITION_WIDTH;
  localparam int CW  = (PW > LIMIT_W) ? PW : LIMIT_W;
  localparam int IW  = $clog2(BYTES_MAX);
  localparam int KW  = $clog2(BYTES_MAX + 1);
  localparam int SW  = 8 * (BYTES_MAX + 1);

  logic [LIMIT_W-1:0]            limit_r;

  logic                          a_valid_r;
  logic [CMD_W-1:0]              a_cmd_r;
  logic [VALUE_W-1:0]            a_value_r;
  logic [CB_W-1:0]               a_cb_r;
  logic                          a_load;

  code_t                         coder_out;
  code_t                         c_code_r;
  logic                          c_valid_r;
  logic                          c_load;

  logic [7:0]                    pend_r, pend_nxt;
  logic [2:0]                    pc_r, pc_nxt;
  logic [PW-1:0]                 wr_r, wr_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          buf_valid_r;
  logic [BYTES_MAX-1:0][7:0]     byte_r, byte_nxt;
  logic [PW-1:0]                 pos_r;
  logic [KW-1:0]                 cnt_r, k;
  logic [IW-1:0]                 idx_r;
  logic                          fb_r;

  logic [SW-1:0]                 stream, src, shifted;
  logic [5:0]                    cnt;
  logic [2:0]                    nb;
  logic [PW-1:0]                 w;
  logic                          go, restart;
  logic                          fire, drain, last, buf_free;

  rgbp_coder u_coder (
    .command  (a_cmd_r),
    .value    (a_value_r),
    .codebook (a_cb_r),
    .code     (coder_out)
  );

  // handshake flow
  always_comb begin
    last     = ({1'b0, idx_r} == KW'(cnt_r - KW'(1)));
    drain    = buf_valid_r && !out_stall;
    buf_free = !buf_valid_r || (drain && last);
    fire     = c_valid_r && ((k == '0) || buf_free);
    c_load   = !c_valid_r || fire;
    a_load   = !a_valid_r || c_load;
    in_stall = !a_load;
  end

  // bit packing and byte limit
  always_comb begin
    stream  = {pend_r, 32'd0} | ({c_code_r.bits, 8'd0} >> pc_r);
    cnt     = 6'(pc_r) + c_code_r.nbits;
    nb      = '0;
    pc_nxt  = pc_r;
    pend_nxt = pend_r;
    ovf_nxt = ovf_r;
    restart = 1'b0;
    src     = {pend_r, 32'd0};
    shifted = '0;
    case (c_code_r.cmd)
      CMD_ENCODE: begin
        src      = stream;
        nb       = cnt[5:3];
        pc_nxt   = cnt[2:0];
        shifted  = stream << {nb, 3'b000};
        pend_nxt = shifted[SW-1 -: 8];
        ovf_nxt  = ovf_r | c_code_r.fallback;
      end
      CMD_FLUSH: begin
        if (pc_r != 3'd0) nb = 3'd1;
        pc_nxt   = '0;
        pend_nxt = '0;
      end
      CMD_RESTART: begin
        pc_nxt   = '0;
        pend_nxt = '0;
        restart  = 1'b1;
      end
      default: begin
        nb = '0;
      end
    endcase

    w  = wr_r;
    k  = '0;
    go = 1'b1;
    for (int j = 0; j < BYTES_MAX; j++) begin
      byte_nxt[j] = src[SW-1-8*j -: 8];
      if (go && (3'(j) < nb) && (CW'(w) < CW'(limit_r))) begin
        k = k + KW'(1);
        w = w + PW'(1);
      end else begin
        go = 1'b0;
      end
    end
    wr_nxt = restart ? '0 : w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      a_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      pend_r      <= '0;
      pc_r        <= '0;
      wr_r        <= '0;
      ovf_r       <= 1'b0;
      buf_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (a_load) a_valid_r <= in_valid;
      if (c_load) c_valid_r <= a_valid_r;
      if (fire) begin
        pend_r <= pend_nxt;
        pc_r   <= pc_nxt;
        wr_r   <= wr_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (fire && (k != '0)) begin
        buf_valid_r <= 1'b1;
        cnt_r       <= k;
        idx_r       <= '0;
      end else if (drain) begin
        if (last) buf_valid_r <= 1'b0;
        else idx_r <= idx_r + IW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (a_load && in_valid) begin
      a_cmd_r   <= in_command;
      a_value_r <= in_value;
      a_cb_r    <= in_codebook;
    end
    if (c_load && a_valid_r) c_code_r <= coder_out;
    if (fire && (k != '0)) begin
      byte_r <= byte_nxt;
      pos_r  <= wr_r;
      fb_r   <= ovf_nxt;
    end else if (drain && !last) begin
      pos_r <= pos_r + PW'(1);
    end
  end

  assign out_valid         = buf_valid_r;
  assign out_byte          = byte_r[idx_r];
  assign out_byte_position = pos_r;
  assign out_last_of_run   = last;
  assign out_fallback_seen = fb_r;

  `RGBP_ASSERT_IMP(a_buf_count, buf_valid_r, (cnt_r != '0) && ({1'b0, idx_r} < cnt_r), "byte buffer index out of range")
  `RGBP_ASSERT_IMP(a_pend_clean, 1'b1, (pend_r & (8'hFF >> pc_r)) == 8'd0, "stale bits below pending count")
  `RGBP_ASSERT_NXT(a_ovf_sticky, fire && c_code_r.fallback, ovf_r, "fallback did not set overflow flag")
  `RGBP_ASSERT_NXT(a_pos_step, drain && !last, pos_r == PW'($past(pos_r) + PW'(1)), "byte position did not advance")

endmodule

// ===== rtl/rgbp_coder.sv =====
// code selection: rice or exponential code, or the single-bit fallback
// depends on rgbp_pkg
module rgbp_coder (
  input  logic [rgbp_pkg::CMD_W-1:0]   command,
  input  logic [rgbp_pkg::VALUE_W-1:0] value,
  input  logic [rgbp_pkg::CB_W-1:0]    codebook,
  output rgbp_pkg::code_t              code
);
  import rgbp_pkg::*;

  logic [3:0]         s, e, r;
  logic [31:0]        q, thr, diff, raw;
  logic [5:0]         len, n;
  logic [6:0]         qx, nx;
  logic [4:0]         sh;
  logic               rice, exp_ok, fb;

  always_comb begin
    s = codebook[11:8];
    e = codebook[7:4];
    r = codebook[3:0];
    q = value >> r;
    rice = (q[31:4] == 28'd0) && (q[3:0] <= s);

    thr  = (32'(s) + 32'd1) << r;
    thr  = thr - (32'd1 << e);
    diff = value - thr;

    len = '0;
    for (int i = 0; i < 32; i++) begin
      if (diff[i]) len = 6'(i + 1);
    end
    qx = 7'(len) + 7'(s) - 7'(e);
    nx = 7'(len) + qx;
    exp_ok = (len > 6'(e)) && (qx <= 7'd31) && (nx <= 7'd32);

    if (rice) begin
      raw = (32'd1 << r) | (value & ((32'd1 << r) - 32'd1));
      n   = 6'(q[3:0]) + 6'd1 + 6'(r);
      fb  = 1'b0;
    end else if (exp_ok) begin
      raw = diff;
      n   = nx[5:0];
      fb  = 1'b0;
    end else begin
      raw = 32'd1;
      n   = 6'd1;
      fb  = 1'b1;
    end

    sh = 5'(6'd32 - n);
    code.cmd      = command;
    code.bits     = raw << sh;
    code.nbits    = n;
    code.fallback = fb && (command == CMD_ENCODE);
  end

endmodule
